// ----- design/lkvc_pkg.sv -----
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// Holds request codes, field widths and the request/response transaction structs.
// No dependencies.
package lkvc_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_W      = 5;
   localparam int REQ_W      = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]      req_type;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } lkvc_req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] found_value;
      logic                  evicted;
      logic [KEY_BITS-1:0]   evicted_key;
   } lkvc_rsp_type;

endpackage

// ----- design/lkvc_match.sv -----
// lkvc_match: parallel key compare and slot selection for the LRU cache.
// Finds the hit entry, the least recent entry and the first free slot, all one-hot.
// Depends on lkvc_pkg.
module lkvc_match
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic [ENTRIES-1:0]                 valid,
   input  logic [KEY_BITS-1:0]                keys [ENTRIES],
   input  logic [$clog2(ENTRIES)-1:0]         ranks [ENTRIES],
   input  logic [KEY_BITS-1:0]                key,
   input  logic [$clog2(ENTRIES)-1:0]         oldest_rank,
   input  logic                               evict_en,
   output logic [ENTRIES-1:0]                 hit_oh,
   output logic [ENTRIES-1:0]                 oldest_oh,
   output logic [ENTRIES-1:0]                 free_oh
);

   logic [ENTRIES-1:0] occupied;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_oh[i]    = valid[i] && (keys[i] == key);
         oldest_oh[i] = valid[i] && (ranks[i] == oldest_rank);
      end
   end

   // the evicted entry frees up before the insert picks its slot
   assign occupied = evict_en ? (valid & ~oldest_oh) : valid;

   // lowest free index wins
   always_comb begin
      free_oh = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!occupied[i]) begin
            free_oh    = '0;
            free_oh[i] = 1'b1;
         end
      end
   end

endmodule

// ----- design/lru_key_value_cache.sv -----
// lru_key_value_cache: fully associative key-to-handle cache, LRU replacement.
// Requests pass the input register, then the result register driving rsp_valid; throughput 1 transaction
// per cycle unless rsp_stall holds the result, set by the single execute stage: parallel key compare and rank update.
// Reset (synchronous, active high) clears all valid bits, ranks and the use count,
// and sets capacity to 16; key and handle storage is not cleared.
// Depends on lkvc_pkg and lkvc_match.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lkvc_req_type     req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lkvc_rsp_type     rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // pipeline registers
   logic         in_valid_ff, in_valid_in;
   lkvc_req_type in_data_ff;
   logic         out_valid_ff, out_valid_in;
   lkvc_rsp_type out_data_ff, rsp_next;

   // cache state
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_ff  [ENTRIES];
   logic [RANK_W-1:0]     rank_in  [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic [CAP_W-1:0]      cap_ff;

   // entry write controls
   logic [ENTRIES-1:0]    key_wr;
   logic [ENTRIES-1:0]    value_wr;

   logic                  accept;
   logic                  advance;
   logic [ENTRIES-1:0]    hit_oh, oldest_oh, free_oh;
   logic                  hit;
   logic [VALUE_BITS-1:0] hit_value;
   logic [KEY_BITS-1:0]   oldest_key;
   logic [RANK_W-1:0]     hit_rank;
   logic [RANK_W-1:0]     oldest_rank;
   logic [CMP_W-1:0]      cap_eff;
   logic                  need_evict;
   logic [CNT_W-1:0]      used_minus1;

   // ---------------------------------------------------------------
   // Handshake: accept into the input register, advance it into the
   // result register when that is empty or being drained.
   // ---------------------------------------------------------------
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Capacity: zero acts as one, anything above ENTRIES saturates.
   // Valid ranks run 0..used-1, so the oldest entry holds rank used-1.
   // ---------------------------------------------------------------
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
   end

   assign need_evict  = CMP_W'(used_ff) >= cap_eff;
   assign used_minus1 = used_ff - CNT_W'(1);
   assign oldest_rank = used_minus1[RANK_W-1:0];

   lkvc_match #(
      .ENTRIES(ENTRIES)
   ) u_match (
      .valid      (valid_ff),
      .keys       (key_ff),
      .ranks      (rank_ff),
      .key        (in_data_ff.key),
      .oldest_rank(oldest_rank),
      .evict_en   (need_evict),
      .hit_oh     (hit_oh),
      .oldest_oh  (oldest_oh),
      .free_oh    (free_oh)
   );

   assign hit = |hit_oh;

   // one-hot selects: at most one entry matches, so OR the masked entries
   always_comb begin
      hit_value  = '0;
      oldest_key = '0;
      hit_rank   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value  = hit_value  | (value_ff[i] & {VALUE_BITS{hit_oh[i]}});
         oldest_key = oldest_key | (key_ff[i]   & {KEY_BITS{oldest_oh[i]}});
         hit_rank   = hit_rank   | (rank_ff[i]  & {RANK_W{hit_oh[i]}});
      end
   end

   // ---------------------------------------------------------------
   // Execute: result and next state for the transaction in the input
   // register. State only moves when the transaction advances.
   // ---------------------------------------------------------------
   always_comb begin
      rsp_next = '0;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      used_in  = used_ff;
      key_wr   = '0;
      value_wr = '0;
      case (in_data_ff.req_type)
         REQ_LOOKUP: begin
            if (hit) begin
               rsp_next.hit         = 1'b1;
               rsp_next.found_value = hit_value;
               // promote: entries more recent than the hit age by one
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_oh[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
            end
         end
         REQ_PUT: begin
            if (hit) begin
               rsp_next.hit = 1'b1;
               value_wr     = hit_oh;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_oh[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
            end else begin
               if (need_evict) begin
                  rsp_next.evicted     = 1'b1;
                  rsp_next.evicted_key = oldest_key;
               end
               // drop the oldest if needed, age the rest, insert as most recent
               for (int i = 0; i < ENTRIES; i++) begin
                  if (free_oh[i]) begin
                     valid_in[i] = 1'b1;
                     rank_in[i]  = '0;
                  end else if (need_evict && oldest_oh[i]) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i]) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
               key_wr   = free_oh;
               value_wr = free_oh;
               if (!need_evict) begin
                  used_in = used_ff + CNT_W'(1);
               end
            end
         end
         REQ_DELETE: begin
            if (hit) begin
               rsp_next.hit         = 1'b1;
               rsp_next.found_value = hit_value;
               // less recent entries move up by one
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_oh[i]) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
                     rank_in[i] = rank_ff[i] - RANK_W'(1);
                  end
               end
               used_in = used_minus1;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= CAP_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (advance) begin
            valid_ff <= valid_in;
            used_ff  <= used_in;
            rank_ff  <= rank_in;
         end
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
         for (int i = 0; i < ENTRIES; i++) begin
            if (key_wr[i]) begin
               key_ff[i] <= in_data_ff.key;
            end
            if (value_wr[i]) begin
               value_ff[i] <= in_data_ff.value;
            end
         end
      end
   end

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for lru_key_value_cache.
// Holds a mirror of the cache that predicts each response, plus drivers for requests,
// capacity writes and response stalls. Depends on lkvc_pkg and the cache RTL.
module tb_top
   import lkvc_pkg::*;
();

   localparam int ENTRIES        = 16;
   localparam int CYCLE_LIMIT    = 500000;
   localparam int PHASE_ITEMS    = 200;
   localparam int MAX_PRINTED    = 30;
   localparam int POOL_MAX       = 32;
   // the request type that the cache leaves alone
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // ---------------------------------------------------------------------------
   // Mirror of the cache contents. Every accepted request transaction updates the
   // copy the same way the cache must and queues the response it must produce.
   // ---------------------------------------------------------------------------
   class cache_mirror;
      bit [KEY_BITS-1:0]   slot_key[ENTRIES];
      bit [VALUE_BITS-1:0] slot_val[ENTRIES];
      bit                  slot_live[ENTRIES];
      bit [3:0]            slot_age[ENTRIES];   // 0 is most recent
      bit [CAP_W-1:0]      live_count;
      bit [CAP_W-1:0]      cap_reg;
      lkvc_rsp_type        predicted[$];
      int                  errors;

      function new();
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = '0;
         end
         live_count = '0;
         cap_reg    = CAP_RESET;
         errors     = 0;
      endfunction

      function void set_capacity(bit [CAP_W-1:0] v);
         cap_reg = v;
      endfunction

      function int lookup_slot(bit [KEY_BITS-1:0] k);
         for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_key[i] == k)
               return i;
         return -1;
      endfunction

      // make idx the most recent; the ones younger than it age by one
      function void promote(int idx);
         bit [3:0] r;
         r = slot_age[idx];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_age[i] < r)
               slot_age[i]++;
         slot_age[idx] = '0;
      endfunction

      // invalidate idx; the ones older than it move up by one
      function void remove(int idx);
         bit [3:0] r;
         r = slot_age[idx];
         slot_live[idx] = 1'b0;
         slot_age[idx]  = '0;
         for (int i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_age[i] > r)
               slot_age[i]--;
         if (live_count > 0)
            live_count--;
      endfunction

      function void note_request(lkvc_req_type r);
         lkvc_rsp_type want;
         int           idx;
         int           oldest;
         int           free_slot;
         int           cap;
         want = '0;
         idx  = lookup_slot(r.key);
         case (r.req_type)
            REQ_LOOKUP, REQ_DELETE: begin
               if (idx >= 0) begin
                  want.hit         = 1'b1;
                  want.found_value = slot_val[idx];
                  if (r.req_type == REQ_LOOKUP)
                     promote(idx);
                  else
                     remove(idx);
               end
            end
            REQ_PUT: begin
               if (idx >= 0) begin
                  want.hit      = 1'b1;
                  slot_val[idx] = r.value;
                  promote(idx);
               end else begin
                  cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
                  // a full cache gives up its single oldest entry, even when over capacity
                  if (live_count >= cap) begin
                     oldest = -1;
                     for (int i = 0; i < ENTRIES; i++)
                        if (slot_live[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                           oldest = i;
                     if (oldest >= 0) begin
                        want.evicted     = 1'b1;
                        want.evicted_key = slot_key[oldest];
                        remove(oldest);
                     end
                  end
                  free_slot = -1;
                  for (int i = 0; i < ENTRIES; i++)
                     if (!slot_live[i] && free_slot < 0)
                        free_slot = i;
                  if (free_slot >= 0) begin
                     for (int i = 0; i < ENTRIES; i++)
                        if (slot_live[i])
                           slot_age[i]++;
                     slot_key[free_slot]  = r.key;
                     slot_val[free_slot]  = r.value;
                     slot_live[free_slot] = 1'b1;
                     slot_age[free_slot]  = '0;
                     live_count++;
                  end
               end
            end
            default: ;
         endcase
         predicted.push_back(want);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("mismatch #%0d at %0t: %s got %h want %h", errors, $realtime, what,
                     got, want);
      endtask

      task check_response(lkvc_rsp_type got);
         lkvc_rsp_type want;
         if (predicted.size() == 0) begin
            report("response with nothing outstanding", 64'(got.found_value), '0);
            return;
         end
         want = predicted.pop_front();
         if (got.hit !== want.hit)
            report("hit", 64'(got.hit), 64'(want.hit));
         if (got.found_value !== want.found_value)
            report("found_value", 64'(got.found_value), 64'(want.found_value));
         if (got.evicted !== want.evicted)
            report("evicted", 64'(got.evicted), 64'(want.evicted));
         if (got.evicted_key !== want.evicted_key)
            report("evicted_key", 64'(got.evicted_key), 64'(want.evicted_key));
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // Clock, DUT and shared state
   // ---------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   lkvc_req_type       req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   lkvc_rsp_type       rsp_payload;
   logic               csr_wr_en;
   logic [CAP_W-1:0]   csr_wr_data;

   cache_mirror        mirror = new();
   int                 cycle_count = 0;
   int                 burst_left;
   int                 stall_mode;
   int                 stall_left;
   bit [KEY_BITS-1:0]  key_pool[POOL_MAX];
   int                 pool_size;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Response side: check every accepted transaction, and stall on a pattern that
   // switches between no stalls, light, heavy and periodic stalling.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
         stall_left <= 50;
      end else begin
         // values seen here were settled before the edge
         if (rsp_valid && !rsp_stall)
            mirror.check_response(rsp_payload);
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= (cycle_count % 3 == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Present one transaction, hold it until accepted, then advance the burst.
   // Called and returns at a rising edge.
   task automatic send_request(lkvc_req_type r);
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      mirror.note_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // drop valid for a gap, then start a new burst; now and then a long one
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 16);
      end
   endtask

   // Hold off until every predicted response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.predicted.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(bit [CAP_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      mirror.set_capacity(v);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic lkvc_req_type make_req(logic [REQ_W-1:0] t, logic [KEY_BITS-1:0] k,
                                             logic [VALUE_BITS-1:0] v);
      lkvc_req_type r;
      r.req_type = t;
      r.key      = k;
      r.value    = v;
      return r;
   endfunction

   // Keys come mostly from a pool a bit larger than the capacity, so hits,
   // misses and evictions all show up; a few keys are fully random.
   function automatic lkvc_req_type random_request();
      int                    roll;
      logic [REQ_W-1:0]      t;
      logic [KEY_BITS-1:0]   k;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         t = REQ_PUT;
      else if (roll < 75)
         t = REQ_LOOKUP;
      else if (roll < 95)
         t = REQ_DELETE;
      else
         t = REQ_UNUSED;
      if ($urandom_range(0, 9) == 0)
         k = $urandom;
      else
         k = key_pool[$urandom_range(0, pool_size - 1)];
      return make_req(t, k, $urandom);
   endfunction

   function automatic void refill_pool(int cap_eff);
      pool_size = cap_eff + $urandom_range(1, 8);
      for (int i = 0; i < POOL_MAX; i++)
         key_pool[i] = $urandom;
      if ($urandom_range(0, 3) == 0)
         key_pool[0] = '0;
      if ($urandom_range(0, 3) == 0)
         key_pool[pool_size - 1] = '1;
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      bit [CAP_W-1:0] cap_plan[10];
      int             cap_eff;
      cap_plan = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      burst_left  = 5;
      pool_size   = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty cache misses, the ignored request type, extreme keys and handles,
      // put over a present key, delete hit and its later miss.
      send_request(make_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000));
      send_request(make_req(REQ_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(REQ_UNUSED, 32'h0000_0005, 32'hFFFF_FFFF));
      send_request(make_req(REQ_PUT,    32'h0000_0000, 32'hFFFF_FFFF));
      send_request(make_req(REQ_PUT,    32'hFFFF_FFFF, 32'h0000_0000));
      send_request(make_req(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000));
      send_request(make_req(REQ_PUT,    32'h0000_0000, 32'h1234_5678));
      send_request(make_req(REQ_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
      send_request(make_req(REQ_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
      send_request(make_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));

      // Small capacity: eviction order follows recency, a lookup refreshes an entry.
      write_capacity(5'd2);
      send_request(make_req(REQ_PUT,    32'hA5A5_0001, 32'h0000_0011));
      send_request(make_req(REQ_PUT,    32'hA5A5_0002, 32'h0000_0022));
      send_request(make_req(REQ_LOOKUP, 32'hA5A5_0001, 32'h0000_0000));
      send_request(make_req(REQ_PUT,    32'hA5A5_0003, 32'h0000_0033));
      send_request(make_req(REQ_PUT,    32'hA5A5_0004, 32'h0000_0044));

      // Capacity zero acts as one, and now sits below the use count:
      // each new key pushes out only the single oldest entry.
      write_capacity(5'd0);
      send_request(make_req(REQ_PUT,    32'h5A5A_0005, 32'h0000_0055));
      send_request(make_req(REQ_PUT,    32'h5A5A_0006, 32'h0000_0066));
      send_request(make_req(REQ_LOOKUP, 32'hA5A5_0004, 32'h0000_0000));

      // Random phases over a spread of capacities, saturating ones included.
      foreach (cap_plan[p]) begin
         write_capacity(cap_plan[p]);
         cap_eff = (cap_plan[p] == 0) ? 1 : ((cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p]);
         refill_pool(cap_eff);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_request(random_request());
      end

      settle();
      repeat (10) @(posedge clock);
      if (mirror.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
